@@ design/iff_pkg.sv @@
// Shared types and constants for the integer field formatter.
// No dependencies; the digit unit and the top level use it by scoped names.
`timescale 1ns / 1ps

package iff_pkg;

   // Conversion kinds
   localparam logic [2:0] CMD_SDEC  = 3'd0;
   localparam logic [2:0] CMD_UDEC  = 3'd1;
   localparam logic [2:0] CMD_LHEX  = 3'd2;
   localparam logic [2:0] CMD_UHEX  = 3'd3;
   localparam logic [2:0] CMD_PCT   = 3'd4;

   // Character codes
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   // Digit storage: ten digits cover any 32-bit value in decimal
   localparam int          NUM_DIGITS = 10;
   localparam int          DIG_IDX_W  = 4;

   // Character counts within one item (field width is at most 63)
   localparam int          CNT_W      = 7;

   // Reciprocal of ten, scaled by 2^35, exact for all 32-bit dividends
   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // Request into the digit unit
   typedef struct packed {
      logic        start;
      logic        hex;
      logic [31:0] value;
   } div_req_type;

   // Result out of the digit unit, valid the cycle after start
   typedef struct packed {
      logic [31:0] quotient;
      logic [3:0]  remainder;
   } div_rsp_type;

endpackage

@@ design/iff_digit_unit.sv @@
// Digit unit: splits a value into quotient and low digit for base ten or sixteen.
// Depends on iff_pkg for the request and result structs and the reciprocal.
`timescale 1ns / 1ps

module iff_digit_unit (
   input  logic                 clock,
   input  iff_pkg::div_req_type div_req,
   output iff_pkg::div_rsp_type div_rsp
);

   logic [63:0] product_ff;
   logic [63:0] product_in;
   logic [31:0] value_ff;
   logic        hex_ff;
   logic [31:0] quot_dec;
   logic [31:0] quot_times_ten;

   // Multiply by the scaled reciprocal and hold the operand
   assign product_in = 64'(div_req.value) * 64'(iff_pkg::RECIP_TEN);

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         product_ff <= product_in;
         value_ff   <= div_req.value;
         hex_ff     <= div_req.hex;
      end
   end

   // Take the quotient from the product and recover the remainder
   assign quot_dec       = 32'(product_ff >> iff_pkg::RECIP_SHIFT);
   assign quot_times_ten = (quot_dec << 3) + (quot_dec << 1);

   always_comb begin
      if (hex_ff) begin
         div_rsp.quotient  = value_ff >> 4;
         div_rsp.remainder = value_ff[3:0];
      end else begin
         div_rsp.quotient  = quot_dec;
         div_rsp.remainder = value_ff[3:0] - quot_times_ten[3:0];
      end
   end

endmodule

@@ design/integer_field_formatter.sv @@
// Integer field formatter top level: sequencer, digit store and output register.
// Depends on iff_pkg and iff_digit_unit.
`timescale 1ns / 1ps

// The block takes one conversion item and streams its characters out one per
// result, the last one flagged, each carrying the running character total.
// Digits come from the reciprocal-multiply digit unit, which is asked once per
// digit (up to ten digits for decimal, eight for hex) in the multiply and fix
// states, followed by the size and place states and then the characters, one
// per cycle while the result side does not stall. A percent item skips the
// digit phase. Requests with an unknown kind are taken and produce no result,
// as does an item with no characters. The next item is taken as soon as the
// last character sits in the output register.

module integer_field_formatter #(
   parameter int MAX_FIELD = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_value,
   input  logic [5:0]  req_field_width,
   input  logic [5:0]  req_precision,
   input  logic        req_has_dot,
   input  logic        req_zero_pad,
   input  logic        req_left_justify,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char,
   output logic [31:0] rsp_total_count
);

   localparam int CW = iff_pkg::CNT_W;
   localparam int IW = iff_pkg::DIG_IDX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_FIX   = 3'd2;
   localparam logic [2:0] ST_SIZE  = 3'd3;
   localparam logic [2:0] ST_PLACE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   localparam logic [5:0] WIDTH_CAP = 6'(MAX_FIELD);
   localparam logic [5:0] PREC_CAP  = 6'(MAX_FIELD - 1);

   logic [2:0]    state_ff, state_in;
   logic          hex_ff, upper_ff, pct_ff, neg_ff, left_ff, zero_ff, dot_ff, mag_zero_ff;
   logic [5:0]    width_ff, prec_ff;
   logic [31:0]   val_ff;
   logic [IW-1:0] nd_ff;
   logic [3:0]    digit_buf_ff [iff_pkg::NUM_DIGITS];
   logic [CW-1:0] zeros_ff, body_ff;
   logic [CW-1:0] b1_ff, b2_ff, b3_ff, b4_ff, total_ff, pos_ff;
   logic [IW-1:0] dp_ff;
   logic [31:0]   char_total_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_char_ff;
   logic          rsp_last_ff;
   logic [31:0]   rsp_total_ff;

   iff_pkg::div_req_type div_req;
   iff_pkg::div_rsp_type div_rsp;

   logic          req_fire;
   logic          emit_fire;
   logic [IW-1:0] nd_eff;
   logic [CW-1:0] zeros_a, body_a, width_x, pad_w, lead_w;
   logic [7:0]    cur_char;
   logic [7:0]    digit_char;
   logic [3:0]    cur_digit;
   logic          is_digit_pos;
   logic          is_last;

   iff_digit_unit u_digit (
      .clock   (clock),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Drive the digit unit from the working value
   assign div_req.start = (state_ff == ST_MUL);
   assign div_req.hex   = hex_ff;
   assign div_req.value = val_ff;

   // Size the body: zeros from precision, then zeros from the zero flag
   assign width_x = CW'(width_ff);
   always_comb begin
      nd_eff  = (dot_ff && prec_ff == 6'd0 && mag_zero_ff) ? '0 : nd_ff;
      zeros_a = (CW'(prec_ff) > CW'(nd_eff)) ? CW'(prec_ff) - CW'(nd_eff) : '0;
      body_a  = CW'(neg_ff) + zeros_a + CW'(nd_eff);
      pad_w   = (width_x > body_ff) ? width_x - body_ff : '0;
      lead_w  = left_ff ? '0 : pad_w;
   end

   // Pick the character at the current position
   assign cur_digit    = digit_buf_ff[dp_ff];
   assign is_digit_pos = (pos_ff >= b3_ff) && (pos_ff < b4_ff);
   assign is_last      = (pos_ff == total_ff - CW'(1));
   always_comb begin
      if (cur_digit < 4'd10) begin
         digit_char = iff_pkg::CH_ZERO + 8'(cur_digit);
      end else begin
         digit_char = (upper_ff ? iff_pkg::CH_UPPER_A : iff_pkg::CH_LOWER_A)
                      + 8'(cur_digit) - 8'd10;
      end
      if (pos_ff < b1_ff) begin
         cur_char = iff_pkg::CH_SPACE;
      end else if (pos_ff < b2_ff) begin
         cur_char = iff_pkg::CH_MINUS;
      end else if (pos_ff < b3_ff) begin
         cur_char = iff_pkg::CH_ZERO;
      end else if (pos_ff < b4_ff) begin
         cur_char = pct_ff ? iff_pkg::CH_PCT : digit_char;
      end else begin
         cur_char = iff_pkg::CH_SPACE;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_command <= iff_pkg::CMD_PCT) begin
               state_in = (req_command == iff_pkg::CMD_PCT) ? ST_SIZE : ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_FIX;
         ST_FIX:   state_in = (div_rsp.quotient == 32'd0) ? ST_SIZE : ST_MUL;
         ST_SIZE:  state_in = ST_PLACE;
         ST_PLACE: state_in = ((body_ff + pad_w) == '0) ? ST_IDLE : ST_EMIT;
         ST_EMIT: begin
            if (emit_fire && is_last) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         char_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_fire) begin
            char_total_ff <= char_total_ff + 32'd1;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Item fields, digit store and layout
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hex_ff   <= (req_command == iff_pkg::CMD_LHEX) ||
                           (req_command == iff_pkg::CMD_UHEX);
               upper_ff <= (req_command == iff_pkg::CMD_UHEX);
               pct_ff   <= (req_command == iff_pkg::CMD_PCT);
               left_ff  <= req_left_justify;
               dot_ff   <= req_has_dot && (req_command != iff_pkg::CMD_PCT);
               zero_ff  <= req_zero_pad && !req_left_justify &&
                           (!req_has_dot || req_command == iff_pkg::CMD_PCT);
               width_ff <= (req_field_width > WIDTH_CAP) ? WIDTH_CAP : req_field_width;
               if (!req_has_dot || req_command == iff_pkg::CMD_PCT) begin
                  prec_ff <= '0;
               end else begin
                  prec_ff <= (req_precision > PREC_CAP) ? PREC_CAP : req_precision;
               end
               neg_ff      <= (req_command == iff_pkg::CMD_SDEC) && req_value[31];
               val_ff      <= ((req_command == iff_pkg::CMD_SDEC) && req_value[31])
                              ? 32'd0 - req_value : req_value;
               mag_zero_ff <= (req_value == 32'd0) && (req_command != iff_pkg::CMD_PCT);
               nd_ff       <= (req_command == iff_pkg::CMD_PCT) ? IW'(1) : '0;
            end
         end
         ST_FIX: begin
            digit_buf_ff[nd_ff] <= div_rsp.remainder;
            nd_ff               <= nd_ff + IW'(1);
            val_ff              <= div_rsp.quotient;
         end
         ST_SIZE: begin
            nd_ff <= nd_eff;
            dp_ff <= nd_eff - IW'(1);
            if (zero_ff && width_x > body_a) begin
               zeros_ff <= zeros_a + (width_x - body_a);
               body_ff  <= width_x;
            end else begin
               zeros_ff <= zeros_a;
               body_ff  <= body_a;
            end
         end
         ST_PLACE: begin
            b1_ff    <= lead_w;
            b2_ff    <= lead_w + CW'(neg_ff);
            b3_ff    <= lead_w + CW'(neg_ff) + zeros_ff;
            b4_ff    <= lead_w + CW'(neg_ff) + zeros_ff + CW'(nd_ff);
            total_ff <= body_ff + pad_w;
            pos_ff   <= '0;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               pos_ff <= pos_ff + CW'(1);
               if (is_digit_pos) begin
                  dp_ff <= dp_ff - IW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_char_ff  <= cur_char;
         rsp_last_ff  <= is_last;
         rsp_total_ff <= char_total_ff + 32'd1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_char   = rsp_last_ff;
   assign rsp_total_count = rsp_total_ff;

   // Checks on the sequencer and the digit store
   a_digit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && is_digit_pos && !pct_ff) |-> (dp_ff < nd_ff))
      else $error("digit pointer outside stored digits");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pos_ff < total_ff))
      else $error("character position past end of item");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && is_last) |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("last character did not end the item");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (nd_ff < IW'(iff_pkg::NUM_DIGITS)))
      else $error("digit store overflow");

   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      !emit_fire |=> $stable(char_total_ff))
      else $error("character total moved without a character");

endmodule
